// ===== sv/stq_pkg.sv =====
`default_nettype none

package stq_pkg;

  // Queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int DL_W   = 48;
  localparam int TAG_W  = 16;
  localparam int WAIT_W = 32;
  localparam int OCC_W  = 5;
  localparam int ST_W   = 3;

  // Input kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POLL   = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_FIRED    = 3'd2;
  localparam logic [ST_W-1:0] ST_WAITING  = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

  // One stored timer
  typedef struct packed {
    logic [DL_W-1:0]  deadline;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/stq_cell.sv =====
`default_nettype none

module stq_cell
  import stq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_cmd_t cmd,
  input  wire entry_t    ins_entry,
  input  wire entry_t    left_entry,
  input  wire logic      left_valid,
  input  wire logic      left_gt,
  input  wire entry_t    right_entry,
  input  wire logic      right_valid,
  output entry_t         entry,
  output logic           valid,
  output logic           gt
);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   vld_r;
  logic   vld_nxt;

  // Flag a held deadline strictly later than the one being inserted
  assign gt = vld_r && (ent_r.deadline > ins_entry.deadline);

  // Pick the next content: shift right, take the new timer, or shift left
  always_comb begin
    ent_nxt = ent_r;
    vld_nxt = vld_r;
    if (cmd.ins) begin
      if (left_gt) begin
        ent_nxt = left_entry;
        vld_nxt = left_valid;
      end else if ((gt || !vld_r) && left_valid) begin
        ent_nxt = ins_entry;
        vld_nxt = 1'b1;
      end
    end else if (cmd.pop) begin
      ent_nxt = right_entry;
      vld_nxt = right_valid;
    end
  end

  // Hold the valid flag; reset clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign entry = ent_r;
  assign valid = vld_r;

endmodule

`default_nettype wire

// ===== sv/sorted_timer_queue.sv =====
`default_nettype none

// Sorted timer queue.
// Input channel (in_*): one transfer per command. in_tuser selects insert (0)
// or poll (1); in_tdata carries the tag and deadline for an insert and the
// current time for a poll. Inserts land in deadline order behind any equal
// deadline; an insert into a full queue is dropped and flagged.
// Result channel (out_*): exactly one result per command, in command order,
// with status in out_tuser and tag, time left and occupancy in out_tdata.
// A row of QUEUE_DEPTH cells holds the timers, head in cell 0. Every cell
// compares its deadline with the incoming one in parallel and shifts toward
// the tail on insert or toward the head on a fired poll, so the result shows
// on out_* the cycle after its transfer, and one command can transfer every
// cycle while out_tready stays high.
// When the receiver stalls, the result is held in the output register and
// in_tready drops until it is taken; nothing is lost.
// Reset empties the queue and drops any pending result; there is no clearing
// pass, so commands are taken from the first cycle after reset.
module sorted_timer_queue
  import stq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [15:0] timer_tag, [63:16] deadline, [111:64] now
  input  wire logic [111:0] in_tdata,
  // [0] kind
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [15:0] fired_tag, [47:16] time_to_next, [52:48] occupancy, [55:53] zero
  output logic [55:0]       out_tdata,
  // [2:0] status
  output logic [ST_W-1:0]   out_tuser
);

  logic              in_xfer;
  logic [TAG_W-1:0]  in_tag;
  logic [DL_W-1:0]   in_deadline;
  logic [DL_W-1:0]   in_now;
  entry_t            ins_entry;
  cell_cmd_t         cmd;

  entry_t                 cell_ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_vld;
  logic [QUEUE_DEPTH-1:0] cell_gt;

  logic              full;
  logic              empty;
  logic              due;
  logic [DL_W-1:0]   diff;

  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              out_vld_r;
  logic [ST_W-1:0]   st_r;
  logic [ST_W-1:0]   st_nxt;
  logic [TAG_W-1:0]  tag_r;
  logic [TAG_W-1:0]  tag_nxt;
  logic [WAIT_W-1:0] wait_r;
  logic [WAIT_W-1:0] wait_nxt;
  logic [OCC_W-1:0]  occ_r;

  // Unpack the input transfer
  assign in_tag      = in_tdata[15:0];
  assign in_deadline = in_tdata[63:16];
  assign in_now      = in_tdata[111:64];
  assign in_tready   = !out_vld_r || out_tready;
  assign in_xfer     = in_tvalid && in_tready;

  assign ins_entry.deadline = in_deadline;
  assign ins_entry.tag      = in_tag;

  // Head state
  assign full  = cell_vld[QUEUE_DEPTH-1];
  assign empty = !cell_vld[0];
  assign due   = in_now >= cell_ent[0].deadline;
  assign diff  = cell_ent[0].deadline - in_now;

  // Broadcast the command to the row
  assign cmd.ins = in_xfer && (in_tuser == KIND_INSERT) && !full;
  assign cmd.pop = in_xfer && (in_tuser == KIND_POLL) && !empty && due;

  // Build the row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_ent;
    logic   left_vld;
    logic   left_gt;
    entry_t right_ent;
    logic   right_vld;

    if (i == 0) begin : g_head
      assign left_ent = ins_entry;
      assign left_vld = 1'b1;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_ent = cell_ent[i-1];
      assign left_vld = cell_vld[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_ent = ins_entry;
      assign right_vld = 1'b0;
    end else begin : g_body
      assign right_ent = cell_ent[i+1];
      assign right_vld = cell_vld[i+1];
    end

    stq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .ins_entry   (ins_entry),
      .left_entry  (left_ent),
      .left_valid  (left_vld),
      .left_gt     (left_gt),
      .right_entry (right_ent),
      .right_valid (right_vld),
      .entry       (cell_ent[i]),
      .valid       (cell_vld[i]),
      .gt          (cell_gt[i])
    );
  end

  // Form the result of the current command
  always_comb begin
    st_nxt   = ST_INSERTED;
    tag_nxt  = '0;
    wait_nxt = '0;
    cnt_nxt  = cnt_r;
    if (in_tuser == KIND_INSERT) begin
      if (full) begin
        st_nxt = ST_FULL;
      end else begin
        st_nxt  = ST_INSERTED;
        cnt_nxt = cnt_r + 1'b1;
      end
    end else if (empty) begin
      st_nxt = ST_EMPTY;
    end else if (due) begin
      st_nxt  = ST_FIRED;
      tag_nxt = cell_ent[0].tag;
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      st_nxt   = ST_WAITING;
      wait_nxt = (|diff[DL_W-1:WAIT_W]) ? '1 : diff[WAIT_W-1:0];
    end
  end

  // Advance the count and the output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        cnt_r     <= cnt_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      st_r   <= st_nxt;
      tag_r  <= tag_nxt;
      wait_r <= wait_nxt;
      occ_r  <= OCC_W'(cnt_nxt);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = st_r;
  assign out_tdata  = {3'b000, occ_r, wait_r, tag_r};

  // Count never runs past the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("timer count exceeds queue depth");

  // Valid cells stay packed toward the head
  a_vld_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_vld & (cell_vld + 1'b1)) == '0)
    else $error("valid cells not contiguous from head");

  // Count tracks the number of valid cells
  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_vld) == 32'(cnt_r))
    else $error("count disagrees with valid cells");

  // A poll of an empty queue reports empty
  a_poll_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser == KIND_POLL) && (cnt_r == '0) |=> out_tuser == ST_EMPTY)
    else $error("poll of empty queue not reported empty");

endmodule

`default_nettype wire
